/* src/i2cm_pkg.sv */
// shared types and constants for the i2c register access unit
package i2cm_pkg;

  // command queue between front end and sequencer
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // opcodes on the input channel
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_DEV_ADDR = 2'd0;
  localparam logic [1:0] CFG_HALF     = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT  = 2'd2;

  // configuration reset values
  localparam logic [6:0] DEV_ADDR_RST = 7'd105;
  localparam logic [7:0] HALF_RST     = 8'd5;
  localparam logic [7:0] TIMEOUT_RST  = 8'd250;

  localparam int BYTE_BITS = 8;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic           full;
    logic           empty;
    logic [QCW-1:0] count;
  } q_stat_t;

  // byte within the transfer
  typedef enum logic [1:0] {
    STG_ADDR_W = 2'd0,
    STG_REG    = 2'd1,
    STG_DATA   = 2'd2,
    STG_ADDR_R = 2'd3
  } stage_t;

  typedef enum logic [15:0] {
    PH_IDLE      = 16'h0001,
    PH_START_A   = 16'h0002,
    PH_START_B   = 16'h0004,
    PH_START_C   = 16'h0008,
    PH_BIT_LOW   = 16'h0010,
    PH_BIT_HIGH  = 16'h0020,
    PH_ACK_LOW   = 16'h0040,
    PH_ACK_HIGH  = 16'h0080,
    PH_RS_A      = 16'h0100,
    PH_RD_LOW    = 16'h0200,
    PH_RD_HIGH   = 16'h0400,
    PH_NACK_LOW  = 16'h0800,
    PH_NACK_HIGH = 16'h1000,
    PH_STOP_A    = 16'h2000,
    PH_STOP_B    = 16'h4000,
    PH_STOP_C    = 16'h8000
  } phase_t;

endpackage

/* src/i2cm_if.sv */
// channel interfaces: input ticks, result items, configuration writes
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] reg_addr;
  logic [7:0] write_data;
  logic       sda_in;

  modport source (output valid, opcode, reg_addr, write_data, sda_in, input ready);
  modport sink   (input valid, opcode, reg_addr, write_data, sda_in, output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda_out;
  logic       sda_enable;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       ack_error;

  modport source (output valid, scl, sda_out, sda_enable, busy_res, done_res, read_data,
                  ack_error, input ready);
  modport sink   (input valid, scl, sda_out, sda_enable, busy_res, done_res, read_data,
                  ack_error, output ready);
endinterface

interface i2cm_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] addr;
  logic [7:0] wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

/* src/i2cm_front.sv */
// front end: takes input items and classifies the opcode
module i2cm_front
  import i2cm_pkg::*;
(
  i2cm_in_if.sink  in_ch,
  input  q_stat_t  qs,
  output logic     push_valid,
  output item_t    push_item
);

  kind_t kind;

  always_comb begin
    unique case (in_ch.opcode)
      OP_WRITE: kind = KIND_WRITE;
      OP_READ:  kind = KIND_READ;
      default:  kind = KIND_TICK;
    endcase
  end

  assign in_ch.ready          = !qs.full;
  assign push_valid           = in_ch.valid && !qs.full;
  assign push_item.kind       = kind;
  assign push_item.reg_addr   = in_ch.reg_addr;
  assign push_item.write_data = in_ch.write_data;
  assign push_item.sda_in     = in_ch.sda_in;

endmodule

/* src/i2cm_queue.sv */
// short item queue between front end and sequencer
module i2cm_queue
  import i2cm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  input  item_t   push_item,
  input  logic    pop,
  output item_t   head,
  output q_stat_t qs
);

  item_t          entry_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push_valid ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    count_nxt  = count_r + QCW'(push_valid) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  assign head     = entry_r[rd_ptr_r];
  assign qs.full  = (count_r == QCW'(QDEPTH));
  assign qs.empty = (count_r == '0);
  assign qs.count = count_r;

endmodule

/* src/i2cm_seq.sv */
// back end: bus sequencer, configuration registers and result register
module i2cm_seq
  import i2cm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  i2cm_cfg_if.sink  cfg_ch,
  input  item_t     head,
  input  q_stat_t   qs,
  output logic      pop,
  i2cm_out_if.source out_ch
);

  // configuration
  logic [6:0] dev_addr_r;
  logic [7:0] half_r;
  logic [7:0] timeout_r;

  // sequencer state
  phase_t     phase_r, phase_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] tick_r, tick_nxt;
  logic [7:0] wait_r, wait_nxt;
  logic [7:0] held_reg_r, held_reg_nxt;
  logic [7:0] held_data_r, held_data_nxt;
  logic       is_read_r, is_read_nxt;
  logic [7:0] recv_r, recv_nxt;
  logic       err_r, err_nxt;
  stage_t     stage_r, stage_nxt;

  // result register
  logic       out_valid_r;
  logic       scl_r, sdo_r, en_r, busy_r, done_r;
  logic [7:0] rdata_r;
  logic       aerr_r;

  // step outputs
  logic       scl, sdo, en, busy, done;

  logic       take;

  assign take   = !out_valid_r || out_ch.ready;
  assign pop    = take && !qs.empty;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RST;
      half_r     <= HALF_RST;
      timeout_r  <= TIMEOUT_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        CFG_DEV_ADDR: dev_addr_r <= cfg_ch.wdata[6:0];
        CFG_HALF:     half_r     <= cfg_ch.wdata;
        CFG_TIMEOUT:  timeout_r  <= cfg_ch.wdata;
        default:      ;
      endcase
    end
  end

  always_comb begin
    phase_t     ph_e;
    logic [7:0] tick_e;
    logic [7:0] wait_e;
    stage_t     stage_e;
    logic       err_e;
    logic       msb;
    logic [7:0] seg_len;
    logic       seg_done;
    logic [7:0] tick_adv;
    logic [3:0] bit_inc;
    logic [7:0] shift_rd;

    ph_e          = phase_r;
    tick_e        = tick_r;
    wait_e        = wait_r;
    stage_e       = stage_r;
    err_e         = err_r;
    held_reg_nxt  = held_reg_r;
    held_data_nxt = held_data_r;
    is_read_nxt   = is_read_r;

    // start of a transfer takes effect on this tick
    if (phase_r == PH_IDLE && (head.kind == KIND_WRITE || head.kind == KIND_READ)) begin
      held_reg_nxt  = head.reg_addr;
      held_data_nxt = head.write_data;
      is_read_nxt   = (head.kind == KIND_READ);
      err_e         = 1'b0;
      stage_e       = STG_ADDR_W;
      tick_e        = '0;
      wait_e        = '0;
      ph_e          = PH_START_A;
    end

    msb      = shift_r[7];
    seg_len  = (half_r == '0) ? 8'd1 : half_r;
    seg_done = ({1'b0, tick_e} + 9'd1) >= {1'b0, seg_len};
    tick_adv = seg_done ? 8'd0 : tick_e + 8'd1;
    bit_inc  = bit_r + 4'd1;
    shift_rd = (tick_e == '0) ? {shift_r[6:0], head.sda_in} : shift_r;

    scl  = 1'b1;
    sdo  = 1'b1;
    en   = 1'b1;
    busy = 1'b1;
    done = 1'b0;

    phase_nxt = ph_e;
    tick_nxt  = tick_e;
    wait_nxt  = wait_e;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    stage_nxt = stage_e;
    recv_nxt  = recv_r;
    err_nxt   = err_e;

    unique case (ph_e)
      PH_IDLE: begin
        busy = 1'b0;
      end
      PH_START_A: begin
        tick_nxt = tick_adv;
        if (seg_done) phase_nxt = PH_START_B;
      end
      PH_START_B: begin
        sdo      = 1'b0;
        tick_nxt = tick_adv;
        if (seg_done) phase_nxt = PH_START_C;
      end
      PH_START_C: begin
        scl      = 1'b0;
        sdo      = 1'b0;
        tick_nxt = tick_adv;
        if (seg_done) begin
          shift_nxt = {dev_addr_r, stage_e == STG_ADDR_R};
          bit_nxt   = '0;
          phase_nxt = PH_BIT_LOW;
        end
      end
      PH_BIT_LOW: begin
        scl      = 1'b0;
        sdo      = msb;
        tick_nxt = tick_adv;
        if (seg_done) phase_nxt = PH_BIT_HIGH;
      end
      PH_BIT_HIGH: begin
        sdo      = msb;
        tick_nxt = tick_adv;
        if (seg_done) begin
          shift_nxt = {shift_r[6:0], 1'b0};
          bit_nxt   = bit_inc;
          if (bit_inc >= 4'(BYTE_BITS)) begin
            wait_nxt  = '0;
            phase_nxt = PH_ACK_LOW;
          end else begin
            phase_nxt = PH_BIT_LOW;
          end
        end
      end
      PH_ACK_LOW: begin
        scl      = 1'b0;
        sdo      = 1'b0;
        en       = 1'b0;
        tick_nxt = tick_adv;
        if (seg_done) phase_nxt = PH_ACK_HIGH;
      end
      PH_ACK_HIGH: begin
        sdo = 1'b0;
        en  = 1'b0;
        if (!head.sda_in && seg_done) begin
          tick_nxt = '0;
          wait_nxt = '0;
          unique case (stage_e)
            STG_ADDR_W: begin
              stage_nxt = STG_REG;
              shift_nxt = held_reg_r;
              bit_nxt   = '0;
              phase_nxt = PH_BIT_LOW;
            end
            STG_REG: begin
              if (is_read_r) begin
                stage_nxt = STG_ADDR_R;
                phase_nxt = PH_RS_A;
              end else begin
                stage_nxt = STG_DATA;
                shift_nxt = held_data_r;
                bit_nxt   = '0;
                phase_nxt = PH_BIT_LOW;
              end
            end
            STG_DATA: begin
              phase_nxt = PH_STOP_A;
            end
            default: begin
              shift_nxt = '0;
              bit_nxt   = '0;
              phase_nxt = PH_RD_LOW;
            end
          endcase
        end else begin
          if (!seg_done) tick_nxt = tick_e + 8'd1;
          if (head.sda_in) begin
            if (wait_e >= timeout_r) begin
              err_nxt   = 1'b1;
              tick_nxt  = '0;
              wait_nxt  = '0;
              phase_nxt = PH_STOP_A;
            end else begin
              wait_nxt = wait_e + 8'd1;
            end
          end
        end
      end
      PH_RS_A: begin
        scl      = 1'b0;
        tick_nxt = tick_adv;
        if (seg_done) phase_nxt = PH_START_A;
      end
      PH_RD_LOW: begin
        scl      = 1'b0;
        sdo      = 1'b0;
        en       = 1'b0;
        tick_nxt = tick_adv;
        if (seg_done) phase_nxt = PH_RD_HIGH;
      end
      PH_RD_HIGH: begin
        sdo       = 1'b0;
        en        = 1'b0;
        shift_nxt = shift_rd;
        tick_nxt  = tick_adv;
        if (seg_done) begin
          bit_nxt = bit_inc;
          if (bit_inc >= 4'(BYTE_BITS)) begin
            recv_nxt  = shift_rd;
            phase_nxt = PH_NACK_LOW;
          end else begin
            phase_nxt = PH_RD_LOW;
          end
        end
      end
      PH_NACK_LOW: begin
        scl      = 1'b0;
        tick_nxt = tick_adv;
        if (seg_done) phase_nxt = PH_NACK_HIGH;
      end
      PH_NACK_HIGH: begin
        tick_nxt = tick_adv;
        if (seg_done) phase_nxt = PH_STOP_A;
      end
      PH_STOP_A: begin
        scl      = 1'b0;
        sdo      = 1'b0;
        tick_nxt = tick_adv;
        if (seg_done) phase_nxt = PH_STOP_B;
      end
      PH_STOP_B: begin
        sdo      = 1'b0;
        tick_nxt = tick_adv;
        if (seg_done) phase_nxt = PH_STOP_C;
      end
      PH_STOP_C: begin
        tick_nxt = tick_adv;
        if (seg_done) begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
      end
      default: begin
        busy      = 1'b0;
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_r       <= '0;
      shift_r     <= '0;
      tick_r      <= '0;
      wait_r      <= '0;
      held_reg_r  <= '0;
      held_data_r <= '0;
      is_read_r   <= 1'b0;
      recv_r      <= '0;
      err_r       <= 1'b0;
      stage_r     <= STG_ADDR_W;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r     <= phase_nxt;
        bit_r       <= bit_nxt;
        shift_r     <= shift_nxt;
        tick_r      <= tick_nxt;
        wait_r      <= wait_nxt;
        held_reg_r  <= held_reg_nxt;
        held_data_r <= held_data_nxt;
        is_read_r   <= is_read_nxt;
        recv_r      <= recv_nxt;
        err_r       <= err_nxt;
        stage_r     <= stage_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      scl_r   <= scl;
      sdo_r   <= sdo;
      en_r    <= en;
      busy_r  <= busy;
      done_r  <= done;
      rdata_r <= recv_nxt;
      aerr_r  <= err_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.scl        = scl_r;
  assign out_ch.sda_out    = sdo_r;
  assign out_ch.sda_enable = en_r;
  assign out_ch.busy_res   = busy_r;
  assign out_ch.done_res   = done_r;
  assign out_ch.read_data  = rdata_r;
  assign out_ch.ack_error  = aerr_r;

endmodule

/* src/i2c_master_register_access_unit.sv */
// top level of the i2c single-byte register read/write master
// an accepted tick item is written into the queue, then popped into the result register
// throughput: one tick item per cycle while the result receiver does not stall
// the queue holds up to four items so input and output stall independently
// reset: synchronous active-low rst_n empties the queue, idles the bus
// sequencer and restores device address 105, half period 5, ack timeout 250
module i2c_master_register_access_unit
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  i2cm_in_if.sink     in_ch,
  i2cm_out_if.source  out_ch,
  i2cm_cfg_if.sink    cfg_ch
);

  // front end to queue
  logic    push_valid;
  item_t   push_item;

  // queue to sequencer
  item_t   head;
  q_stat_t qs;
  logic    pop;

  // front end: handshake on the input channel and opcode classification
  i2cm_front u_front (
    .in_ch      (in_ch),
    .qs         (qs),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  // decoupling queue, lets the sequencer stall on the result side alone
  i2cm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .pop        (pop),
    .head       (head),
    .qs         (qs)
  );

  // back end: one bus tick per popped item, result held in an output register
  i2cm_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .head   (head),
    .qs     (qs),
    .pop    (pop),
    .out_ch (out_ch)
  );

`ifndef SYNTHESIS
  // queue occupancy never goes past its depth
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qs.count <= QCW'(QDEPTH))
    else $error("queue count over depth");

  // a waiting item with a free result slot always produces a result next cycle
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!qs.empty && out_ch.ready) |=> out_ch.valid)
    else $error("queued item not processed");

  // released sda is always reported low
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.sda_enable) |-> !out_ch.sda_out)
    else $error("sda_out high while released");

  // end of a transfer is always inside a busy tick
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.done_res) |-> out_ch.busy_res)
    else $error("done without busy");
`endif

endmodule

/* dv/tb_i2c_master_register_access_unit.sv */
`timescale 1ns / 1ps
// self-checking testbench for the i2c register access unit with a bus sequencer predictor
module tb_i2c_master_register_access_unit
  import i2cm_pkg::*;
();

  // opcode 3 is not a command and must be ignored
  localparam logic [1:0] OP_RSVD = 2'd3;
  // cycles with no handshake on any channel before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  // long receiver hold-off used to fill the command queue
  localparam int HOLD_CYCLES = 200;
  // ticks in the random part
  localparam int RANDOM_TICKS = 60;
  // no forced missing acknowledge in a transfer
  localparam int NO_NACK = -1;

  // one predicted bus tick
  typedef struct {
    logic       scl;
    logic       sda_out;
    logic       sda_en;
    logic       busy;
    logic       done;
    logic [7:0] rd_byte;
    logic       nack_err;
  } bus_tick_t;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  i2cm_in_if  in_ch();
  i2cm_out_if out_ch();
  i2cm_cfg_if cfg_ch();

  i2c_master_register_access_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predicted bus ticks not yet seen on the result channel
  bus_tick_t pending_bus[$];

  // mirror of the configuration registers
  logic [6:0] m_dev;
  logic [7:0] m_half;
  logic [7:0] m_tmo;

  // mirror of the sequencer state
  phase_t     m_ph;
  stage_t     m_stg;
  logic [3:0] m_bits;
  logic [7:0] m_shift;
  logic [7:0] m_tick;
  logic [7:0] m_wait;
  logic [7:0] m_reg;
  logic [7:0] m_data;
  logic       m_rd;
  logic [7:0] m_rx;
  logic       m_err;

  // stimulus shaping
  int         nack_at;     // stage whose acknowledge is held high, or NO_NACK
  logic [7:0] rx_pattern;  // byte the emulated target returns on a read
  bit         no_idle;     // both sides run without gaps
  bit         hold_out;    // request one long receiver hold-off
  int         ticks_sent;
  int         fails;

  // ---------------------------------------------------------------------------
  // sequencer predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_sequencer();
    m_dev   = DEV_ADDR_RST;
    m_half  = HALF_RST;
    m_tmo   = TIMEOUT_RST;
    m_ph    = PH_IDLE;
    m_stg   = STG_ADDR_W;
    m_bits  = '0;
    m_shift = '0;
    m_tick  = '0;
    m_wait  = '0;
    m_reg   = '0;
    m_data  = '0;
    m_rd    = 1'b0;
    m_rx    = '0;
    m_err   = 1'b0;
  endfunction

  // a zero half period behaves as one tick
  function automatic int seg_len();
    return (m_half == 8'd0) ? 1 : int'(m_half);
  endfunction

  // count one tick of the current scl segment, true when the segment ends
  function automatic bit seg_done();
    if (int'(m_tick) + 1 >= seg_len()) begin
      m_tick = '0;
      return 1'b1;
    end
    m_tick = m_tick + 8'd1;
    return 1'b0;
  endfunction

  function automatic void load_byte(input logic [7:0] b);
    m_shift = b;
    m_bits  = '0;
    m_ph    = PH_BIT_LOW;
  endfunction

  // advance the bus by one tick and queue what the block must drive for it
  function automatic void step_sequencer(input logic [1:0] op, input logic [7:0] ra,
                                         input logic [7:0] wd, input logic sda);
    bus_tick_t r;
    logic      msb;
    r.scl = 1'b1;
    r.sda_out = 1'b1;
    r.sda_en = 1'b1;
    r.busy = 1'b1;
    r.done = 1'b0;

    // a command in idle starts the start condition on this same tick
    if (m_ph == PH_IDLE && (op == OP_WRITE || op == OP_READ)) begin
      m_reg  = ra;
      m_data = wd;
      m_rd   = (op == OP_READ);
      m_err  = 1'b0;
      m_stg  = STG_ADDR_W;
      m_tick = '0;
      m_wait = '0;
      m_ph   = PH_START_A;
    end

    // drive levels for this tick
    msb = m_shift[7];
    case (m_ph)
      PH_START_A, PH_NACK_HIGH, PH_STOP_C: ;
      PH_START_B: r.sda_out = 1'b0;
      PH_START_C: begin
        r.scl = 1'b0;
        r.sda_out = 1'b0;
      end
      PH_BIT_LOW: begin
        r.scl = 1'b0;
        r.sda_out = msb;
      end
      PH_BIT_HIGH: r.sda_out = msb;
      PH_ACK_LOW, PH_RD_LOW: begin
        r.scl = 1'b0;
        r.sda_out = 1'b0;
        r.sda_en = 1'b0;
      end
      PH_ACK_HIGH, PH_RD_HIGH: begin
        r.sda_out = 1'b0;
        r.sda_en = 1'b0;
      end
      PH_RS_A, PH_NACK_LOW: r.scl = 1'b0;
      PH_STOP_A: begin
        r.scl = 1'b0;
        r.sda_out = 1'b0;
      end
      PH_STOP_B: r.sda_out = 1'b0;
      default: begin
        m_ph = PH_IDLE;
        r.busy = 1'b0;
      end
    endcase

    // next state
    case (m_ph)
      PH_START_A: if (seg_done()) m_ph = PH_START_B;
      PH_START_B: if (seg_done()) m_ph = PH_START_C;
      PH_START_C: if (seg_done()) load_byte({m_dev, m_stg == STG_ADDR_R});
      PH_BIT_LOW: if (seg_done()) m_ph = PH_BIT_HIGH;
      PH_BIT_HIGH: begin
        if (seg_done()) begin
          m_shift = m_shift << 1;
          m_bits  = m_bits + 4'd1;
          if (m_bits >= 4'd8) begin
            m_wait = '0;
            m_ph   = PH_ACK_LOW;
          end else begin
            m_ph = PH_BIT_LOW;
          end
        end
      end
      PH_ACK_LOW: if (seg_done()) m_ph = PH_ACK_HIGH;
      PH_ACK_HIGH: begin
        // ack only counts once the high segment has run its length
        if (!sda && int'(m_tick) + 1 >= seg_len()) begin
          m_tick = '0;
          m_wait = '0;
          case (m_stg)
            STG_ADDR_W: begin
              m_stg = STG_REG;
              load_byte(m_reg);
            end
            STG_REG: begin
              if (m_rd) begin
                m_stg = STG_ADDR_R;
                m_ph  = PH_RS_A;
              end else begin
                m_stg = STG_DATA;
                load_byte(m_data);
              end
            end
            STG_DATA: m_ph = PH_STOP_A;
            default: begin
              m_shift = '0;
              m_bits  = '0;
              m_ph    = PH_RD_LOW;
            end
          endcase
        end else begin
          if (int'(m_tick) + 1 < seg_len()) m_tick = m_tick + 8'd1;
          // high sda counts toward the timeout, abort once it is reached
          if (sda) begin
            if (m_wait >= m_tmo) begin
              m_err  = 1'b1;
              m_tick = '0;
              m_wait = '0;
              m_ph   = PH_STOP_A;
            end else begin
              m_wait = m_wait + 8'd1;
            end
          end
        end
      end
      PH_RS_A: if (seg_done()) m_ph = PH_START_A;
      PH_RD_LOW: if (seg_done()) m_ph = PH_RD_HIGH;
      PH_RD_HIGH: begin
        // sample on the first tick of the high segment
        if (m_tick == 8'd0) m_shift = {m_shift[6:0], sda};
        if (seg_done()) begin
          m_bits = m_bits + 4'd1;
          if (m_bits >= 4'd8) begin
            m_rx = m_shift;
            m_ph = PH_NACK_LOW;
          end else begin
            m_ph = PH_RD_LOW;
          end
        end
      end
      PH_NACK_LOW: if (seg_done()) m_ph = PH_NACK_HIGH;
      PH_NACK_HIGH: if (seg_done()) m_ph = PH_STOP_A;
      PH_STOP_A: if (seg_done()) m_ph = PH_STOP_B;
      PH_STOP_B: if (seg_done()) m_ph = PH_STOP_C;
      PH_STOP_C: begin
        if (seg_done()) begin
          m_ph = PH_IDLE;
          r.done = 1'b1;
        end
      end
      default: ;
    endcase

    r.rd_byte = m_rx;
    r.nack_err = m_err;
    pending_bus.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly back to back, sometimes short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // sda as the emulated target would present it on the coming tick
  function automatic logic pick_sda();
    case (m_ph)
      PH_ACK_HIGH: begin
        if (int'(m_stg) == nack_at) return 1'b1;
        return ($urandom_range(3) == 0);
      end
      PH_RD_HIGH: begin
        if (m_tick == 8'd0) return rx_pattern[7 - int'(m_bits)];
        return 1'($urandom_range(1));
      end
      default: return 1'($urandom_range(1));
    endcase
  endfunction

  // offer one item, predict it once accepted, then maybe idle
  task automatic send_tick(input logic [1:0] op, input logic [7:0] ra, input logic [7:0] wd,
                           input logic sda);
    int gap;
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.reg_addr   <= ra;
    in_ch.write_data <= wd;
    in_ch.sda_in     <= sda;
    do @(posedge clk); while (!in_ch.ready);
    step_sequencer(op, ra, wd, sda);
    ticks_sent++;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // any opcode while busy must be ignored, so ticks carry random commands
  task automatic random_tick();
    send_tick(2'($urandom_range(3)), 8'($urandom_range(255)), 8'($urandom_range(255)),
              pick_sda());
  endtask

  // start a transfer from idle and keep ticking until the bus is idle again
  task automatic run_transfer(input logic [1:0] op, input logic [7:0] ra, input logic [7:0] wd,
                              input int nack, input logic [7:0] pattern);
    nack_at = nack;
    rx_pattern = pattern;
    send_tick(op, ra, wd, 1'($urandom_range(1)));
    while (m_ph != PH_IDLE) random_tick();
  endtask

  // stop offering and wait for every predicted tick to come out
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_bus.size() != 0);
  endtask

  // write all three registers in one burst, valid held across them
  task automatic configure(input logic [7:0] dev, input logic [7:0] half, input logic [7:0] tmo);
    logic [1:0] idx [3];
    logic [7:0] val [3];
    idx = '{CFG_DEV_ADDR, CFG_HALF, CFG_TIMEOUT};
    val = '{dev, half, tmo};
    for (int i = 0; i < 3; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.addr  <= idx[i];
      cfg_ch.wdata <= val[i];
      do @(posedge clk); while (!cfg_ch.ready);
      case (idx[i])
        CFG_DEV_ADDR: m_dev = val[i][6:0];
        CFG_HALF: m_half = val[i];
        default: m_tmo = val[i];
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // idle bus, plain ticks and the unused opcode must not start anything
  task automatic test_idle_ticks();
    for (int i = 0; i < 6; i++)
      send_tick((i % 2) ? OP_RSVD : OP_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)),
                1'($urandom_range(1)));
  endtask

  // writes with extreme register and data bytes, first at reset settings
  task automatic test_write();
    run_transfer(OP_WRITE, 8'hff, 8'h00, NO_NACK, 8'h00);
    // fast bus from here on
    settle();
    configure(8'd105, 8'd1, 8'd250);
    run_transfer(OP_WRITE, 8'h00, 8'hff, NO_NACK, 8'h00);
  endtask

  // reads returning all ones then all zeros so every read_data bit toggles
  task automatic test_read();
    run_transfer(OP_READ, 8'h00, 8'ha5, NO_NACK, 8'hff);
    run_transfer(OP_READ, 8'h5a, 8'h00, NO_NACK, 8'h00);
  endtask

  // missing acknowledge on two bytes of each transfer kind
  task automatic test_ack_abort();
    settle();
    // zero timeout gives up on the first high tick
    configure(8'd105, 8'd1, 8'd0);
    run_transfer(OP_WRITE, 8'h3c, 8'hc3, int'(STG_DATA), 8'h00);
    run_transfer(OP_READ, 8'h11, 8'h00, int'(STG_ADDR_R), 8'h00);
    settle();
    configure(8'd105, 8'd1, 8'd3);
    run_transfer(OP_WRITE, 8'h22, 8'h44, int'(STG_REG), 8'h00);
    run_transfer(OP_READ, 8'h33, 8'h00, int'(STG_ADDR_W), 8'h00);
  endtask

  // register extremes, including a zero half period and a masked address bit
  task automatic test_config_extremes();
    settle();
    // a clean transfer after an abort clears the error flag
    configure(8'h80, 8'd0, 8'd1);
    run_transfer(OP_READ, 8'h81, 8'h00, NO_NACK, 8'h69);
    // full address byte, aborted after the longest timeout
    settle();
    configure(8'hff, 8'd1, 8'd255);
    run_transfer(OP_WRITE, 8'h01, 8'h02, int'(STG_ADDR_W), 8'h00);
    // default address and timeout on a fast bus
    settle();
    configure(8'(DEV_ADDR_RST), 8'd1, TIMEOUT_RST);
  endtask

  // receiver stops for a long stretch while items keep coming
  task automatic test_backpressure();
    no_idle = 1'b1;
    hold_out = 1'b1;
    run_transfer(OP_READ, 8'($urandom_range(255)), 8'($urandom_range(255)), NO_NACK,
                 8'($urandom_range(255)));
    no_idle = 1'b0;
  endtask

  // mostly well formed transfers with random content, some noise and forced nacks
  task automatic test_random();
    int base;
    int n;
    int r;
    int half;
    int tmo;
    base = ticks_sent;
    n = 0;
    while (ticks_sent - base < RANDOM_TICKS) begin
      if (n % 3 == 0) begin
        settle();
        r = $urandom_range(99);
        half = (r < 50) ? 1 : (r < 80) ? $urandom_range(3, 2) : $urandom_range(6, 4);
        tmo = ($urandom_range(9) == 0) ? 0 : $urandom_range(40, 1);
        configure(8'($urandom_range(255)), 8'(half), 8'(tmo));
      end
      n++;
      no_idle = ($urandom_range(3) == 0);
      r = $urandom_range(99);
      if (r < 15) begin
        repeat ($urandom_range(10, 1))
          send_tick($urandom_range(1) ? OP_TICK : OP_RSVD, 8'($urandom_range(255)),
                    8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        run_transfer($urandom_range(1) ? OP_WRITE : OP_READ, 8'($urandom_range(255)),
                     8'($urandom_range(255)),
                     ($urandom_range(4) == 0) ? $urandom_range(3) : NO_NACK,
                     8'($urandom_range(255)));
      end
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result receiver: random stalls, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end else if (no_idle) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(3) != 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(20, 1)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: every accepted item against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s expected %0h got %0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    bus_tick_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_bus.size() == 0) begin
        $error("result item with no prediction pending");
        fails++;
      end else begin
        want = pending_bus.pop_front();
        check_field("scl", 8'(want.scl), 8'(out_ch.scl));
        check_field("sda_out", 8'(want.sda_out), 8'(out_ch.sda_out));
        check_field("sda_enable", 8'(want.sda_en), 8'(out_ch.sda_enable));
        check_field("busy_res", 8'(want.busy), 8'(out_ch.busy_res));
        check_field("done_res", 8'(want.done), 8'(out_ch.done_res));
        check_field("read_data", want.rd_byte, out_ch.read_data);
        check_field("ack_error", 8'(want.nack_err), 8'(out_ch.ack_error));
      end
    end
  end

  // hang detector: no handshake on any channel for too long
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    fails = 0;
    ticks_sent = 0;
    no_idle = 1'b0;
    hold_out = 1'b0;
    nack_at = NO_NACK;
    rx_pattern = '0;
    reset_sequencer();
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= OP_TICK;
    in_ch.reg_addr   <= '0;
    in_ch.write_data <= '0;
    in_ch.sda_in     <= 1'b1;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.addr      <= CFG_DEV_ADDR;
    cfg_ch.wdata     <= '0;
    rst_n            <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_ticks();
    test_write();
    test_read();
    test_ack_abort();
    test_config_extremes();
    test_backpressure();
    test_random();

    // drain, then give a late stray result time to show up
    settle();
    repeat (8) @(posedge clk);
    if (pending_bus.size() != 0) begin
      $error("%0d predicted results never arrived", pending_bus.size());
      fails++;
    end
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
